// ===== hw/rtl/lpad_pkg.sv =====
`default_nettype none

package lpad_pkg;

  // Parse phase; the encoding doubles as the byte class code.
  typedef enum logic [2:0] {
    PH_COUNT   = 3'd0,
    PH_PLEN    = 3'd1,
    PH_PATH    = 3'd2,
    PH_SIZE    = 3'd3,
    PH_CONTENT = 3'd4,
    PH_TRAIL   = 3'd5
  } lpad_phase_e;

  typedef enum logic [2:0] {
    CLS_COUNT   = 3'd0,
    CLS_PLEN    = 3'd1,
    CLS_PATH    = 3'd2,
    CLS_SIZE    = 3'd3,
    CLS_CONTENT = 3'd4,
    CLS_TRAIL   = 3'd5
  } lpad_class_e;

  typedef enum logic [1:0] {
    ST_BUSY  = 2'd0,
    ST_OK    = 2'd1,
    ST_TRUNC = 2'd2
  } lpad_status_e;

  // Index of the final byte of each little-endian field.
  localparam logic [2:0] CountLastIdx = 3'd3;
  localparam logic [2:0] PlenLastIdx  = 3'd1;
  localparam logic [2:0] SizeLastIdx  = 3'd7;

  typedef struct packed {
    lpad_phase_e  phase;
    logic [2:0]   field_byte_index;
    logic [63:0]  field_accum;
    logic [31:0]  files_left;
    logic [15:0]  path_left;
    logic [63:0]  content_left;
    logic [31:0]  current_file;
  } lpad_state_t;

  localparam lpad_state_t LpadStateReset = '{
    phase:            PH_COUNT,
    field_byte_index: 3'd0,
    field_accum:      64'd0,
    files_left:       32'd0,
    path_left:        16'd0,
    content_left:     64'd0,
    current_file:     32'd0
  };

  typedef struct packed {
    lpad_class_e  byte_class;
    logic [7:0]   data_out;
    logic [31:0]  file_number;
    logic         field_done;
    logic [63:0]  field_value;
    logic         file_end;
    lpad_status_e status;
  } lpad_result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lpad_in_if.sv =====
`default_nettype none

interface lpad_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lpad_out_if.sv =====
`default_nettype none

interface lpad_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  byte_class;
  logic [7:0]  data_out;
  logic [31:0] file_number;
  logic        field_done;
  logic [63:0] field_value;
  logic        file_end;
  logic [1:0]  status;

  modport source (
    output valid, output byte_class, output data_out, output file_number,
    output field_done, output field_value, output file_end, output status,
    input ready
  );
  modport sink (
    input valid, input byte_class, input data_out, input file_number,
    input field_done, input field_value, input file_end, input status,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/lpad_step.sv =====
`default_nettype none

module lpad_step (
  input  var lpad_pkg::lpad_state_t  state_i,
  input  var logic [7:0]             data_byte_i,
  input  var logic                   last_byte_i,
  output lpad_pkg::lpad_state_t      state_o,
  output lpad_pkg::lpad_result_t     result_o
);

  logic [63:0] accum;
  logic [31:0] files_dec;
  lpad_pkg::lpad_state_t nxt;

  // Merge the new byte into the field at its little-endian position.
  assign accum = state_i.field_accum |
                 ({56'd0, data_byte_i} << {state_i.field_byte_index, 3'b000});
  assign files_dec = state_i.files_left - 32'd1;

  always_comb begin
    nxt = state_i;
    result_o.byte_class  = lpad_pkg::CLS_TRAIL;
    result_o.data_out    = data_byte_i;
    result_o.file_number = state_i.current_file;
    result_o.field_done  = 1'b0;
    result_o.field_value = 64'd0;
    result_o.file_end    = 1'b0;
    result_o.status      = lpad_pkg::ST_BUSY;

    case (state_i.phase)
      lpad_pkg::PH_COUNT: begin
        result_o.byte_class  = lpad_pkg::CLS_COUNT;
        result_o.file_number = 32'd0;
        if (state_i.field_byte_index >= lpad_pkg::CountLastIdx) begin
          result_o.field_done  = 1'b1;
          result_o.field_value = {32'd0, accum[31:0]};
          nxt.field_accum      = 64'd0;
          nxt.field_byte_index = 3'd0;
          nxt.files_left       = accum[31:0];
          nxt.phase = (accum[31:0] == 32'd0) ? lpad_pkg::PH_TRAIL : lpad_pkg::PH_PLEN;
        end else begin
          nxt.field_accum      = accum;
          nxt.field_byte_index = state_i.field_byte_index + 3'd1;
        end
      end
      lpad_pkg::PH_PLEN: begin
        result_o.byte_class = lpad_pkg::CLS_PLEN;
        if (state_i.field_byte_index >= lpad_pkg::PlenLastIdx) begin
          result_o.field_done  = 1'b1;
          result_o.field_value = {48'd0, accum[15:0]};
          nxt.field_accum      = 64'd0;
          nxt.field_byte_index = 3'd0;
          nxt.path_left        = accum[15:0];
          nxt.phase = (accum[15:0] == 16'd0) ? lpad_pkg::PH_SIZE : lpad_pkg::PH_PATH;
        end else begin
          nxt.field_accum      = accum;
          nxt.field_byte_index = state_i.field_byte_index + 3'd1;
        end
      end
      lpad_pkg::PH_PATH: begin
        result_o.byte_class = lpad_pkg::CLS_PATH;
        nxt.path_left = state_i.path_left - 16'd1;
        if (state_i.path_left == 16'd1) begin
          nxt.phase = lpad_pkg::PH_SIZE;
        end
      end
      lpad_pkg::PH_SIZE: begin
        result_o.byte_class = lpad_pkg::CLS_SIZE;
        if (state_i.field_byte_index >= lpad_pkg::SizeLastIdx) begin
          result_o.field_done  = 1'b1;
          result_o.field_value = accum;
          nxt.field_accum      = 64'd0;
          nxt.field_byte_index = 3'd0;
          nxt.content_left     = accum;
          if (accum == 64'd0) begin
            // Empty content: close the file on its last size byte.
            result_o.file_end = 1'b1;
            nxt.files_left    = files_dec;
            nxt.current_file  = state_i.current_file + 32'd1;
            nxt.phase = (files_dec == 32'd0) ? lpad_pkg::PH_TRAIL : lpad_pkg::PH_PLEN;
          end else begin
            nxt.phase = lpad_pkg::PH_CONTENT;
          end
        end else begin
          nxt.field_accum      = accum;
          nxt.field_byte_index = state_i.field_byte_index + 3'd1;
        end
      end
      lpad_pkg::PH_CONTENT: begin
        result_o.byte_class = lpad_pkg::CLS_CONTENT;
        nxt.content_left = state_i.content_left - 64'd1;
        if (state_i.content_left == 64'd1) begin
          result_o.file_end = 1'b1;
          nxt.files_left    = files_dec;
          nxt.current_file  = state_i.current_file + 32'd1;
          nxt.phase = (files_dec == 32'd0) ? lpad_pkg::PH_TRAIL : lpad_pkg::PH_PLEN;
        end
      end
      default: begin
        result_o.byte_class = lpad_pkg::CLS_TRAIL;
        nxt.phase           = lpad_pkg::PH_TRAIL;
      end
    endcase

    // Final byte: report completeness and drop back to the reset state.
    if (last_byte_i) begin
      result_o.status = (nxt.phase == lpad_pkg::PH_TRAIL) ? lpad_pkg::ST_OK
                                                          : lpad_pkg::ST_TRUNC;
      nxt = lpad_pkg::LpadStateReset;
    end
  end

  assign state_o = nxt;

endmodule

`default_nettype wire

// ===== hw/rtl/length_prefixed_archive_deframer_top.sv =====
// A byte's result is loaded into the output register at the edge that accepts the byte.
// One byte per cycle unless stalled; parse state updates in the same cycle a byte is taken.
// in_i.ready is high while the output register is empty or being drained this cycle.
// Reset (rst_ni low, asynchronous) clears the parse state to expecting the file count
// and empties the output register.
`default_nettype none

module length_prefixed_archive_deframer_top (
  input  var logic    clk_i,
  input  var logic    rst_ni,
  lpad_in_if.sink     in_i,
  lpad_out_if.source  out_o
);

  // Parse state: phase, field assembly and the remaining path/content/file counters.
  lpad_pkg::lpad_state_t  state_q, state_d;
  // Result register with its valid flag; it parts the input from the output side.
  lpad_pkg::lpad_result_t result_q, result_d;
  logic                   out_valid_q;
  logic                   in_fire;

  // Take a new byte whenever the result register is free or emptying now.
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;

  // All per-byte work: classify, assemble fields, count down, set status.
  lpad_step u_step (
    .state_i     (state_q),
    .data_byte_i (in_i.data_byte),
    .last_byte_i (in_i.last_byte),
    .state_o     (state_d),
    .result_o    (result_d)
  );

  // Advance the parse state only on an accepted byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lpad_pkg::LpadStateReset;
    end else if (in_fire) begin
      state_q <= state_d;
    end
  end

  // Output valid: set on accept, clear when the sink takes the item with nothing behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Payload needs no reset; load it with each accepted byte.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      result_q <= result_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.byte_class  = result_q.byte_class;
  assign out_o.data_out    = result_q.data_out;
  assign out_o.file_number = result_q.file_number;
  assign out_o.field_done  = result_q.field_done;
  assign out_o.field_value = result_q.field_value;
  assign out_o.file_end    = result_q.file_end;
  assign out_o.status      = result_q.status;

`ifndef SYNTH
  // A final byte always leaves the parser in its reset state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_i.last_byte) |=>
      (state_q.phase == lpad_pkg::PH_COUNT && state_q.files_left == 32'd0 &&
       state_q.field_byte_index == 3'd0))
    else $error("parse state not cleared after final byte");

  // Field value is zero unless a field just completed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.field_done) |-> (out_o.field_value == 64'd0))
    else $error("field_value nonzero without field_done");

  // A file can only end on a size or content byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.file_end) |->
      (out_o.byte_class == lpad_pkg::CLS_SIZE || out_o.byte_class == lpad_pkg::CLS_CONTENT))
    else $error("file_end on wrong byte class");

  // Count bytes belong to no file yet.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.byte_class == lpad_pkg::CLS_COUNT) |->
      (out_o.file_number == 32'd0))
    else $error("count byte tagged with nonzero file number");
`endif

endmodule

`default_nettype wire

// ===== tb/length_prefixed_archive_deframer_top_tb.sv =====
`default_nettype none

module length_prefixed_archive_deframer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandomBytes = 800;
  localparam int CycleLimit  = 400000;
  localparam int DrainCycles = 6;

  typedef struct packed {
    logic [7:0] b;
    logic       lst;
    logic       hold;  // wait for every due result before sending this byte
  } arc_byte_t;

  logic clk_i;
  logic rst_ni;

  lpad_in_if  in_if ();
  lpad_out_if out_if ();

  length_prefixed_archive_deframer_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  arc_byte_t              byte_q[$];       // bytes waiting to be sent
  logic [7:0]             arc[$];          // archive under construction
  lpad_pkg::lpad_result_t due_results[$];  // predicted results, oldest first
  lpad_pkg::lpad_state_t  arch_st;         // predicted parse state
  int                     mismatches;
  int                     cycles;
  int                     send_gap;
  int                     stall_left;
  int                     in_calm;
  int                     out_calm;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Mostly short gaps, a few long ones, and now and then a stretch with none.
  function automatic int draw_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // Retire the file in progress and pick what follows it.
  function automatic void close_file();
    arch_st.files_left--;
    arch_st.current_file++;
    arch_st.phase = (arch_st.files_left == 32'd0) ? lpad_pkg::PH_TRAIL : lpad_pkg::PH_PLEN;
  endfunction

  // Advance the parse state by one byte and return the result it produces.
  function automatic lpad_pkg::lpad_result_t parse_byte(input logic [7:0] b, input logic lst);
    lpad_pkg::lpad_result_t r;
    logic [2:0]             idx;
    logic [63:0]            acc;
    r.byte_class  = lpad_pkg::CLS_TRAIL;
    r.data_out    = b;
    r.file_number = arch_st.current_file;
    r.field_done  = 1'b0;
    r.field_value = 64'd0;
    r.file_end    = 1'b0;
    r.status      = lpad_pkg::ST_BUSY;
    idx = arch_st.field_byte_index;
    acc = arch_st.field_accum | ({56'd0, b} << (8 * idx));
    case (arch_st.phase)
      lpad_pkg::PH_COUNT: begin
        r.byte_class  = lpad_pkg::CLS_COUNT;
        r.file_number = 32'd0;
        if (idx == lpad_pkg::CountLastIdx) begin
          r.field_done = 1'b1;
          r.field_value = {32'd0, acc[31:0]};
          arch_st.field_accum = 64'd0;
          arch_st.field_byte_index = 3'd0;
          arch_st.files_left = acc[31:0];
          arch_st.phase = (acc[31:0] == 32'd0) ? lpad_pkg::PH_TRAIL : lpad_pkg::PH_PLEN;
        end else begin
          arch_st.field_accum = acc;
          arch_st.field_byte_index = idx + 3'd1;
        end
      end
      lpad_pkg::PH_PLEN: begin
        r.byte_class = lpad_pkg::CLS_PLEN;
        if (idx == lpad_pkg::PlenLastIdx) begin
          r.field_done = 1'b1;
          r.field_value = {48'd0, acc[15:0]};
          arch_st.field_accum = 64'd0;
          arch_st.field_byte_index = 3'd0;
          arch_st.path_left = acc[15:0];
          // an empty path goes straight on to the size field
          arch_st.phase = (acc[15:0] == 16'd0) ? lpad_pkg::PH_SIZE : lpad_pkg::PH_PATH;
        end else begin
          arch_st.field_accum = acc;
          arch_st.field_byte_index = idx + 3'd1;
        end
      end
      lpad_pkg::PH_PATH: begin
        r.byte_class = lpad_pkg::CLS_PATH;
        arch_st.path_left--;
        if (arch_st.path_left == 16'd0) arch_st.phase = lpad_pkg::PH_SIZE;
      end
      lpad_pkg::PH_SIZE: begin
        r.byte_class = lpad_pkg::CLS_SIZE;
        if (idx == lpad_pkg::SizeLastIdx) begin
          r.field_done = 1'b1;
          r.field_value = acc;
          arch_st.field_accum = 64'd0;
          arch_st.field_byte_index = 3'd0;
          arch_st.content_left = acc;
          if (acc == 64'd0) begin
            // empty content: the file ends on its last size byte
            r.file_end = 1'b1;
            close_file();
          end else begin
            arch_st.phase = lpad_pkg::PH_CONTENT;
          end
        end else begin
          arch_st.field_accum = acc;
          arch_st.field_byte_index = idx + 3'd1;
        end
      end
      lpad_pkg::PH_CONTENT: begin
        r.byte_class = lpad_pkg::CLS_CONTENT;
        arch_st.content_left--;
        if (arch_st.content_left == 64'd0) begin
          r.file_end = 1'b1;
          close_file();
        end
      end
      default: begin
        arch_st.phase = lpad_pkg::PH_TRAIL;
      end
    endcase
    if (lst) begin
      r.status = (arch_st.phase == lpad_pkg::PH_TRAIL) ? lpad_pkg::ST_OK : lpad_pkg::ST_TRUNC;
      arch_st = lpad_pkg::LpadStateReset;
    end
    return r;
  endfunction

  // Append a little-endian field of n bytes to the archive under construction.
  task automatic put_le(input logic [63:0] v, input int n);
    for (int i = 0; i < n; i++) arc = {arc, v[8*i +: 8]};
  endtask

  task automatic put_random(input int n);
    for (int i = 0; i < n; i++) arc = {arc, 8'($urandom)};
  endtask

  // Queue the first keep bytes of the archive, flag the last one, drop the rest.
  task automatic ship(input int keep, input logic hold);
    arc_byte_t item;
    for (int i = 0; i < keep; i++) begin
      item.b    = arc[i];
      item.lst  = (i == keep - 1);
      item.hold = hold && (i == 0);
      byte_q = {byte_q, item};
    end
    arc.delete();
  endtask

  // Build a well-formed archive with random content, sizes mostly small.
  task automatic build_archive();
    int unsigned nfiles;
    int unsigned plen;
    int unsigned sz;
    int          r;
    nfiles = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
    put_le(nfiles, 4);
    repeat (nfiles) begin
      r = $urandom_range(0, 19);
      plen = (r < 5) ? 0 : (r == 19) ? $urandom_range(20, 40) : $urandom_range(1, 5);
      put_le(plen, 2);
      put_random(plen);
      r = $urandom_range(0, 19);
      sz = (r < 5) ? 0 : (r == 19) ? $urandom_range(20, 40) : $urandom_range(1, 5);
      put_le(sz, 8);
      put_random(sz);
    end
    if ($urandom_range(0, 3) == 0) put_random($urandom_range(1, 3));
  endtask

  // Driver: predict each accepted byte, then present the next one after its gap.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        due_results = {due_results, parse_byte(in_if.data_byte, in_if.last_byte)};
      end
      if (!in_if.valid || in_if.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_if.valid <= 1'b0;
        end else if (byte_q.size() != 0 && (!byte_q[0].hold || due_results.size() == 0)) begin
          in_if.valid     <= 1'b1;
          in_if.data_byte <= byte_q[0].b;
          in_if.last_byte <= byte_q[0].lst;
          void'(byte_q.pop_front());
          send_gap = draw_gap(in_calm);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check every accepted result against the oldest prediction.
  always @(posedge clk_i) begin
    lpad_pkg::lpad_result_t want;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (due_results.size() == 0) begin
          $error("result with no byte waiting: class %0d data %0h",
                 out_if.byte_class, out_if.data_out);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          if (out_if.byte_class !== want.byte_class) begin
            $error("byte_class: expected %0d, got %0d", want.byte_class, out_if.byte_class);
            mismatches++;
          end
          if (out_if.data_out !== want.data_out) begin
            $error("data_out: expected %0h, got %0h", want.data_out, out_if.data_out);
            mismatches++;
          end
          if (out_if.file_number !== want.file_number) begin
            $error("file_number: expected %0d, got %0d", want.file_number, out_if.file_number);
            mismatches++;
          end
          if (out_if.field_done !== want.field_done) begin
            $error("field_done: expected %0b, got %0b", want.field_done, out_if.field_done);
            mismatches++;
          end
          if (out_if.field_value !== want.field_value) begin
            $error("field_value: expected %0h, got %0h", want.field_value, out_if.field_value);
            mismatches++;
          end
          if (out_if.file_end !== want.file_end) begin
            $error("file_end: expected %0b, got %0b", want.file_end, out_if.file_end);
            mismatches++;
          end
          if (out_if.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_if.status);
            mismatches++;
          end
        end
      end
      // stall the result side independently of what the block is doing
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        stall_left = draw_gap(out_calm);
      end
    end
  end

  // Bound the run in case the handshake hangs.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("FAIL length_prefixed_archive_deframer_top");
      $finish;
    end
  end

  initial begin
    int sel;
    int target;
    // hold every input at a known value from time zero
    in_if.valid     = 1'b0;
    in_if.data_byte = 8'd0;
    in_if.last_byte = 1'b0;
    out_if.ready    = 1'b0;
    rst_ni          = 1'b0;
    arch_st         = lpad_pkg::LpadStateReset;
    mismatches      = 0;
    cycles          = 0;
    send_gap        = 0;
    stall_left      = 0;
    in_calm         = 0;
    out_calm        = 0;

    // final byte inside the count field: truncated
    arc = {arc, 8'hFF};
    ship(1, 1'b0);
    // zero file count, then a trailing byte that carries the final flag
    put_le(0, 4);
    arc = {arc, 8'hFF};
    ship(arc.size(), 1'b0);
    // two files: empty path with empty content, then one path byte and one content byte
    put_le(2, 4);
    put_le(0, 2);
    put_le(0, 8);
    put_le(1, 2);
    arc = {arc, 8'hFF};
    put_le(1, 8);
    arc = {arc, 8'h00};
    ship(arc.size(), 1'b0);

    // random archives; the first one waits for the directed results to drain
    target = byte_q.size() + RandomBytes;
    build_archive();
    ship(arc.size(), 1'b1);
    while (byte_q.size() < target) begin
      sel = $urandom_range(0, 19);
      if (sel < 14) begin
        build_archive();
        ship(arc.size(), $urandom_range(0, 29) == 0);
      end else if (sel < 17) begin
        // cut a well-formed archive short
        build_archive();
        ship($urandom_range(1, arc.size()), 1'b0);
      end else if (sel < 19) begin
        put_random($urandom_range(1, 24));
        ship(arc.size(), 1'b0);
      end else begin
        // huge random size, truncated partway into the content
        put_le($urandom, 4);
        put_le(0, 2);
        put_le({$urandom, $urandom}, 8);
        put_random($urandom_range(0, 5));
        ship(arc.size(), 1'b0);
      end
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // drain: nothing left to send, nothing in flight, nothing due
    while (byte_q.size() != 0 || in_if.valid || due_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("PASS length_prefixed_archive_deframer_top");
    end else begin
      $display("FAIL length_prefixed_archive_deframer_top");
    end
    $finish;
  end

endmodule

`default_nettype wire
